[hdl/ihash_pkg.sv]
// Package for the inode hash table: command codes, field widths, the
// command and result words, and the node word width helper. No dependencies.
package ihash_pkg;

	localparam int SLOT_W    = 10;
	localparam int DEV_W     = 32;
	localparam int INO_W     = 64;
	localparam int MINOR_W   = 24;

	localparam int BUCKETS_DEF = 1024;
	localparam int SLOTS_DEF   = 1024;

	// command codes; the fourth code is a no-op
	localparam logic [1:0] CMD_LOOKUP = 2'd0;
	localparam logic [1:0] CMD_INSERT = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [DEV_W-1:0]  device;
		logic [INO_W-1:0]  inode_number;
		logic [SLOT_W-1:0] slot;
	} ihash_req_t;

	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] match_slot;
	} ihash_rsp_t;

	// node word: hashed mark, next link, back link, device, inode
	function automatic int node_width(int slots, int buckets);
		return 1 + $clog2(slots + 1) + $clog2(slots + buckets) + DEV_W + INO_W;
	endfunction

endpackage

[hdl/ihash_ram.sv]
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data. No package dependency.
module ihash_ram #(
	parameter int DEPTH = 2,
	parameter int WIDTH = 1,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[hdl/ihash_ctrl.sv]
// Sequencer of the inode hash table: clearing pass, chain walk, insert and
// remove read-modify-write steps over the bucket and node RAMs. Uses ihash_pkg.
module ihash_ctrl #(
	parameter int BUCKETS = ihash_pkg::BUCKETS_DEF,
	parameter int SLOTS   = ihash_pkg::SLOTS_DEF,
	localparam int BW     = $clog2(BUCKETS),
	localparam int SW     = $clog2(SLOTS),
	localparam int NW     = $clog2(SLOTS + 1),
	localparam int NODE_W = ihash_pkg::node_width(SLOTS, BUCKETS)
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  ihash_pkg::ihash_req_t   command,
	output logic                    done,
	output ihash_pkg::ihash_rsp_t   result,
	// bucket head RAM
	output logic                    b_we,
	output logic [BW-1:0]           b_waddr,
	output logic [NW-1:0]           b_wdata,
	output logic                    b_re,
	output logic [BW-1:0]           b_raddr,
	input  logic [NW-1:0]           b_rdata,
	// node RAM
	output logic                    n_we,
	output logic [SW-1:0]           n_waddr,
	output logic [NODE_W-1:0]       n_wdata,
	output logic                    n_re,
	output logic [SW-1:0]           n_raddr,
	input  logic [NODE_W-1:0]       n_rdata
);
	import ihash_pkg::*;

	localparam int PW   = $clog2(SLOTS + BUCKETS);
	localparam int CLRN = (BUCKETS > SLOTS) ? BUCKETS : SLOTS;
	localparam int CW   = $clog2(CLRN);
	localparam logic [NW-1:0] NULL_LINK = NW'(SLOTS);
	localparam logic [PW-1:0] HEAD_BASE = PW'(SLOTS);
	localparam logic [CW-1:0] CLR_LAST  = CW'(CLRN - 1);

	typedef struct packed {
		logic             hashed;
		logic [NW-1:0]    next;
		logic [PW-1:0]    prev;
		logic [DEV_W-1:0] dev;
		logic [INO_W-1:0] ino;
	} node_t;

	typedef enum logic [3:0] {
		ST_CLR, ST_IDLE, ST_DISP, ST_LK_HEAD, ST_LK_NODE,
		ST_INS_CHK, ST_INS_OLD, ST_RM_CHK, ST_RM_PV, ST_RM_NX
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     clr_q;
	logic [1:0]        cmd_q;
	logic [DEV_W-1:0]  dev_q;
	logic [INO_W-1:0]  ino_q;
	logic [SLOT_W-1:0] slot_q;
	logic [BW-1:0]     bkt_q;
	logic [SW-1:0]     cur_q;
	logic [NW-1:0]     nx_q;
	logic [PW-1:0]     pv_q;
	logic              done_q;
	logic              found_q;
	logic [SLOT_W-1:0] match_q;

	node_t             rd;
	node_t             wr;
	logic              slot_ok;
	logic [SW-1:0]     s_idx;
	logic              head_ok;
	logic              next_ok;
	logic              nxq_ok;
	logic              key_hit;
	logic              pv_node;

	assign rd      = node_t'(n_rdata);
	assign n_wdata = NODE_W'(wr);
	assign slot_ok = int'(slot_q) < SLOTS;
	assign s_idx   = SW'(slot_q);
	assign head_ok = b_rdata < NULL_LINK;
	assign next_ok = rd.next < NULL_LINK;
	assign nxq_ok  = nx_q < NULL_LINK;
	assign key_hit = (rd.dev == dev_q) && (rd.ino == ino_q);
	assign pv_node = rd.prev < HEAD_BASE;

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = '{found: found_q, match_slot: match_q};

	// drive RAM ports from the current step; the steps never touch one
	// node entry with a read and a write in the same cycle
	always_comb begin
		b_we    = 1'b0;
		b_waddr = bkt_q;
		b_wdata = NULL_LINK;
		b_re    = 1'b0;
		b_raddr = bkt_q;
		n_we    = 1'b0;
		n_waddr = s_idx;
		n_re    = 1'b0;
		n_raddr = s_idx;
		wr      = rd;
		case (state_q)
			ST_CLR: begin
				b_we    = int'(clr_q) < BUCKETS;
				b_waddr = BW'(clr_q);
				n_we    = int'(clr_q) < SLOTS;
				n_waddr = SW'(clr_q);
				wr      = '0;
			end
			ST_DISP: begin
				case (cmd_q)
					CMD_LOOKUP: b_re = 1'b1;
					CMD_INSERT: begin
						b_re = slot_ok;
						n_re = slot_ok;
					end
					CMD_REMOVE: n_re = slot_ok;
					default: ;
				endcase
			end
			ST_LK_HEAD: begin
				n_re    = head_ok;
				n_raddr = SW'(b_rdata);
			end
			ST_LK_NODE: begin
				n_re    = !key_hit && next_ok;
				n_raddr = SW'(rd.next);
			end
			ST_INS_CHK: begin
				// link slot at head, then fetch the old head for its back link
				n_we    = !rd.hashed;
				wr      = '{hashed: 1'b1, next: b_rdata, prev: HEAD_BASE + PW'(bkt_q),
					dev: dev_q, ino: ino_q};
				b_we    = !rd.hashed;
				b_wdata = NW'(s_idx);
				n_re    = !rd.hashed && head_ok;
				n_raddr = SW'(b_rdata);
			end
			ST_INS_OLD: begin
				n_we    = 1'b1;
				n_waddr = cur_q;
				wr.prev = PW'(s_idx);
			end
			ST_RM_CHK: begin
				// drop the mark, then fix the predecessor or the bucket head
				n_we      = rd.hashed;
				wr.hashed = 1'b0;
				n_re      = rd.hashed && (pv_node || next_ok);
				n_raddr   = pv_node ? SW'(rd.prev) : SW'(rd.next);
				b_we      = rd.hashed && !pv_node;
				b_waddr   = BW'(rd.prev - HEAD_BASE);
				b_wdata   = rd.next;
			end
			ST_RM_PV: begin
				n_we    = 1'b1;
				n_waddr = SW'(pv_q);
				wr.next = nx_q;
				n_re    = nxq_ok;
				n_raddr = SW'(nx_q);
			end
			ST_RM_NX: begin
				n_we    = 1'b1;
				n_waddr = SW'(nx_q);
				wr.prev = pv_q;
			end
			default: ;
		endcase
	end

	// sequence state and result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			clr_q   <= '0;
			done_q  <= 1'b0;
			found_q <= 1'b0;
			match_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + CW'(1);
					if (clr_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						cmd_q   <= command.cmd;
						dev_q   <= command.device;
						ino_q   <= command.inode_number;
						slot_q  <= command.slot;
						// low bits of minor + inode; BW must not exceed the minor width (not enforced)
						bkt_q   <= BW'(command.inode_number) + BW'(command.device);
						state_q <= ST_DISP;
					end
				end
				ST_DISP: begin
					found_q <= 1'b0;
					match_q <= '0;
					case (cmd_q)
						CMD_LOOKUP: state_q <= ST_LK_HEAD;
						CMD_INSERT: begin
							state_q <= slot_ok ? ST_INS_CHK : ST_IDLE;
							done_q  <= !slot_ok;
						end
						CMD_REMOVE: begin
							state_q <= slot_ok ? ST_RM_CHK : ST_IDLE;
							done_q  <= !slot_ok;
						end
						default: begin
							state_q <= ST_IDLE;
							done_q  <= 1'b1;
						end
					endcase
				end
				ST_LK_HEAD: begin
					cur_q <= SW'(b_rdata);
					if (head_ok) begin
						state_q <= ST_LK_NODE;
					end else begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				ST_LK_NODE: begin
					if (key_hit) begin
						found_q <= 1'b1;
						match_q <= SLOT_W'(cur_q);
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end else if (next_ok) begin
						cur_q <= SW'(rd.next);
					end else begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				ST_INS_CHK: begin
					cur_q   <= SW'(b_rdata);
					found_q <= !rd.hashed;
					if (!rd.hashed && head_ok) begin
						state_q <= ST_INS_OLD;
					end else begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				ST_INS_OLD: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				ST_RM_CHK: begin
					pv_q    <= rd.prev;
					nx_q    <= rd.next;
					found_q <= rd.hashed;
					if (rd.hashed && pv_node) begin
						state_q <= ST_RM_PV;
					end else if (rd.hashed && next_ok) begin
						state_q <= ST_RM_NX;
					end else begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				ST_RM_PV: begin
					if (nxq_ok) begin
						state_q <= ST_RM_NX;
					end else begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				ST_RM_NX: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// a node entry is never read and written in the same cycle
	a_no_rw_same: assert property (@(posedge clk) disable iff (!arst_n)
		(n_we && n_re) |-> (n_waddr != n_raddr))
		else $error("node RAM read and write collide");
	// result strobe is one cycle wide
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe longer than one cycle");
	// a result appears only once the sequencer is back at rest
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result while busy");
	// a miss reports slot zero
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.found) |-> (result.match_slot == '0))
		else $error("nonzero slot on miss");
	// an accepted word makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not start work");
`endif

endmodule

[hdl/inode_hash_table.sv]
// Top level of the inode hash table: sequencer plus bucket head RAM and
// node RAM. Depends on ihash_pkg, ihash_ram and ihash_ctrl.
//
//  channel  | handshake         | word
//  ---------+-------------------+-----------------------------------------
//  command  | start && !busy    | cmd, device, inode_number, slot
//  result   | done (one cycle)  | found, match_slot
//
// After reset a clearing pass empties all bucket heads and hashed marks;
// busy is high throughout. Lookup reads the bucket head, then walks the
// chain, one node RAM read per node, to a key match or the chain's end.
// Insert links the slot at the head, remove unlinks it; an unused command,
// or insert or remove of a slot out of range, ends at dispatch. The result
// strobe rises in the same cycle as busy falls; results cannot be held off,
// and the next command may be taken while a result is shown. BUCKETS must
// be a power of two (unchecked): the bucket is the low bits of minor + inode.
module inode_hash_table #(
	parameter int BUCKETS = ihash_pkg::BUCKETS_DEF,
	parameter int SLOTS   = ihash_pkg::SLOTS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  ihash_pkg::ihash_req_t command,
	output logic                  done,
	output ihash_pkg::ihash_rsp_t result
);
	import ihash_pkg::*;

	localparam int BW     = $clog2(BUCKETS);
	localparam int SW     = $clog2(SLOTS);
	localparam int NW     = $clog2(SLOTS + 1);
	localparam int NODE_W = node_width(SLOTS, BUCKETS);

	logic              b_we;
	logic [BW-1:0]     b_waddr;
	logic [NW-1:0]     b_wdata;
	logic              b_re;
	logic [BW-1:0]     b_raddr;
	logic [NW-1:0]     b_rdata;
	logic              n_we;
	logic [SW-1:0]     n_waddr;
	logic [NODE_W-1:0] n_wdata;
	logic              n_re;
	logic [SW-1:0]     n_raddr;
	logic [NODE_W-1:0] n_rdata;

	// sequencer
	ihash_ctrl #(.BUCKETS(BUCKETS), .SLOTS(SLOTS)) u_ctrl (
		.clk, .arst_n, .start, .busy, .command, .done, .result,
		.b_we, .b_waddr, .b_wdata, .b_re, .b_raddr, .b_rdata,
		.n_we, .n_waddr, .n_wdata, .n_re, .n_raddr, .n_rdata
	);

	// bucket heads
	ihash_ram #(.DEPTH(BUCKETS), .WIDTH(NW)) u_bucket_ram (
		.clk, .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
		.re(b_re), .raddr(b_raddr), .rdata(b_rdata)
	);

	// node slots: mark, links and key
	ihash_ram #(.DEPTH(SLOTS), .WIDTH(NODE_W)) u_node_ram (
		.clk, .we(n_we), .waddr(n_waddr), .wdata(n_wdata),
		.re(n_re), .raddr(n_raddr), .rdata(n_rdata)
	);

endmodule
